[src/ihp_pkg.sv]
// ihp_pkg: shared types and constants for the IPv4 header parser.
// Used by ihp_front, ihp_queue, ihp_back and ipv4_header_parser_unit.
package ihp_pkg;

  // Width of the saturating byte counter (counts up to 65536)
  localparam int unsigned CNT_W = 17;

  localparam logic [CNT_W-1:0] COUNT_MAX     = 17'd65536;
  localparam logic [CNT_W-1:0] MIN_HDR_BYTES = 17'd20;

  // Byte positions inside the fixed header
  localparam logic [CNT_W-1:0] POS_VER_IHL  = 17'd0;
  localparam logic [CNT_W-1:0] POS_TLEN_HI  = 17'd2;
  localparam logic [CNT_W-1:0] POS_TLEN_LO  = 17'd3;
  localparam logic [CNT_W-1:0] POS_SRC_FROM = 17'd12;
  localparam logic [CNT_W-1:0] POS_DST_FROM = 17'd16;
  localparam logic [CNT_W-1:0] POS_DST_END  = 17'd20;

  localparam logic [3:0] IP_VERSION = 4'd4;
  localparam logic [3:0] MIN_IHL    = 4'd5;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_BAD_HDR   = 2'd2;
  localparam logic [1:0] ST_LEN_ERROR = 2'd3;

  // Input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } ihp_in_t;

  // Result beat
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        packet_end;
    logic [1:0]  parse_status;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
  } ihp_out_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } ihp_q_stat_t;

endpackage

[src/ihp_front.sv]
// ihp_front: accepts packet bytes, tracks header fields and classifies each byte.
// Depends on ihp_pkg; pushes result beats into ihp_queue.
module ihp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ihp_pkg::ihp_in_t     in_data,
  input  ihp_pkg::ihp_q_stat_t q_stat,
  output logic                 push,
  output ihp_pkg::ihp_out_t    push_data
);
  import ihp_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       vi_r, vi_nxt;
  logic [15:0]      tlen_r, tlen_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      dst_r, dst_nxt;

  logic             accept;
  logic [7:0]       vi_cur;
  logic [15:0]      tlen_cur;
  logic [31:0]      src_cur;
  logic [31:0]      dst_cur;
  logic [CNT_W-1:0] count_inc;
  logic [5:0]       hdr_bytes;
  logic             pay;
  logic [1:0]       status;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // Header fields including the current byte
  always_comb begin
    vi_cur   = (count_r == POS_VER_IHL) ? in_data.in_byte : vi_r;
    tlen_cur = tlen_r;
    if (count_r == POS_TLEN_HI) begin
      tlen_cur = {in_data.in_byte, tlen_r[7:0]};
    end else if (count_r == POS_TLEN_LO) begin
      tlen_cur = {tlen_r[15:8], in_data.in_byte};
    end
    src_cur = (count_r >= POS_SRC_FROM && count_r < POS_DST_FROM) ?
              {src_r[23:0], in_data.in_byte} : src_r;
    dst_cur = (count_r >= POS_DST_FROM && count_r < POS_DST_END) ?
              {dst_r[23:0], in_data.in_byte} : dst_r;
  end

  // Classification: payload test and end-of-packet status
  always_comb begin
    count_inc = (count_r >= COUNT_MAX) ? COUNT_MAX : count_r + 17'd1;
    hdr_bytes = {vi_cur[3:0], 2'b00};
    pay = (count_r >= CNT_W'(hdr_bytes)) && (count_r >= MIN_HDR_BYTES) &&
          (count_r < {1'b0, tlen_cur});
    priority if (count_inc < MIN_HDR_BYTES) begin
      status = ST_SHORT;
    end else if (vi_cur[7:4] != IP_VERSION || vi_cur[3:0] < MIN_IHL) begin
      status = ST_BAD_HDR;
    end else if (count_inc != {1'b0, tlen_cur}) begin
      status = ST_LEN_ERROR;
    end else begin
      status = ST_OK;
    end
  end

  // Result beat toward the queue
  always_comb begin
    push                    = accept && (pay || in_data.in_last);
    push_data.payload_valid = pay;
    push_data.payload_byte  = pay ? in_data.in_byte : 8'd0;
    push_data.packet_end    = in_data.in_last;
    push_data.parse_status  = in_data.in_last ? status : ST_OK;
    push_data.source_addr   = in_data.in_last ? src_cur : 32'd0;
    push_data.dest_addr     = in_data.in_last ? dst_cur : 32'd0;
  end

  // Next packet state; cleared after the last byte
  always_comb begin
    count_nxt = count_r;
    vi_nxt    = vi_r;
    tlen_nxt  = tlen_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    if (accept) begin
      if (in_data.in_last) begin
        count_nxt = '0;
        vi_nxt    = '0;
        tlen_nxt  = '0;
        src_nxt   = '0;
        dst_nxt   = '0;
      end else begin
        count_nxt = count_inc;
        vi_nxt    = vi_cur;
        tlen_nxt  = tlen_cur;
        src_nxt   = src_cur;
        dst_nxt   = dst_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      vi_r    <= '0;
      tlen_r  <= '0;
      src_r   <= '0;
      dst_r   <= '0;
    end else begin
      count_r <= count_nxt;
      vi_r    <= vi_nxt;
      tlen_r  <= tlen_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

  // Packet state restarts after an end-of-packet beat
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_data.packet_end |=> count_r == '0 && vi_r == '0 && tlen_r == '0)
    else $error("packet state not cleared after last byte");

  // Counter saturates
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_MAX)
    else $error("byte count beyond saturation");

endmodule

[src/ihp_queue.sv]
// ihp_queue: small register FIFO of result beats between front and back.
// Depends on ihp_pkg.
module ihp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ihp_pkg::ihp_out_t    push_data,
  input  logic                 pop,
  output ihp_pkg::ihp_out_t    pop_data,
  output ihp_pkg::ihp_q_stat_t q_stat
);
  import ihp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ihp_out_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

[src/ihp_back.sv]
// ihp_back: output register stage that drains the queue onto the result port.
// Depends on ihp_pkg; reads from ihp_queue.
module ihp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ihp_pkg::ihp_q_stat_t q_stat,
  input  ihp_pkg::ihp_out_t    pop_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ihp_pkg::ihp_out_t    out_data
);
  import ihp_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  ihp_out_t out_data_r;
  logic     load;

  // Load a new beat when the register is empty or being taken
  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !q_stat.empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= pop_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/ipv4_header_parser_unit.sv]
// Streaming IPv4 header parser: takes one packet byte per beat and returns payload bytes and
// an end-of-packet status with the captured source and destination addresses. One byte is
// accepted every cycle while in_stall is low. The front classifies the byte in the cycle
// it is accepted, and the result beat is written into the queue at that edge. A queue of
// QUEUE_DEPTH result beats sits between the front and the output register, so in_stall
// rises only when the result side has stalled long enough to fill that queue. Bytes that
// produce no result (header bytes and bytes past the total length, other than the last)
// pass through without using a queue slot. Payload beats are tentative: drop the packet's
// payload when the end-of-packet status is not ok.
//
// Depends on ihp_pkg, ihp_front, ihp_queue and ihp_back.
module ipv4_header_parser_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ihp_pkg::ihp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ihp_pkg::ihp_out_t out_data
);
  import ihp_pkg::*;

  ihp_q_stat_t q_stat;
  logic        push;
  ihp_out_t    push_data;
  logic        pop;
  ihp_out_t    pop_data;

  // Front: accept and classify bytes
  ihp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Result queue
  ihp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // Back: output register
  ihp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking bench for ipv4_header_parser_unit, fed with packet bytes
// under random idle and stall. Depends on ihp_pkg and the parser RTL.
module tb_top;
  import ihp_pkg::*;

  localparam int unsigned RUN_LIMIT    = 1000000;
  localparam int unsigned RAND_BYTES   = 1260;
  localparam int unsigned CALM_TAIL    = 200;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Tracks the parser's per-packet state and holds the result beats it should emit
  class ipv4_parse_checker;
    logic [CNT_W-1:0] byte_cnt;
    logic [7:0]       ver_ihl;
    logic [15:0]      tot_len;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    ihp_out_t         want_beats[$];
    int unsigned      errors;

    function new();
      errors = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_cnt = '0;
      ver_ihl  = '0;
      tot_len  = '0;
      src_addr = '0;
      dst_addr = '0;
    endfunction

    function int unsigned pending();
      return want_beats.size();
    endfunction

    // Accepted input beat: update captures, queue a result beat if one is due
    function void note_byte(ihp_in_t beat);
      logic [CNT_W-1:0] idx;
      logic [CNT_W-1:0] cnt;
      logic [CNT_W-1:0] hdr_len;
      bit               pay;
      ihp_out_t         want;
      idx = byte_cnt;
      if (idx == POS_VER_IHL) ver_ihl = beat.in_byte;
      else if (idx == POS_TLEN_HI) tot_len[15:8] = beat.in_byte;
      else if (idx == POS_TLEN_LO) tot_len[7:0] = beat.in_byte;
      else if (idx >= POS_SRC_FROM && idx < POS_DST_FROM) src_addr = {src_addr[23:0], beat.in_byte};
      else if (idx >= POS_DST_FROM && idx < POS_DST_END) dst_addr = {dst_addr[23:0], beat.in_byte};

      cnt = (idx >= COUNT_MAX) ? COUNT_MAX : idx + 1'b1;
      byte_cnt = cnt;

      hdr_len = {{(CNT_W-6){1'b0}}, ver_ihl[3:0], 2'b00};
      pay = (idx >= hdr_len) && (idx >= MIN_HDR_BYTES) && (idx < {1'b0, tot_len});
      if (!pay && !beat.in_last) return;

      want = '0;
      want.payload_valid = pay;
      want.payload_byte  = pay ? beat.in_byte : 8'h00;
      want.packet_end    = beat.in_last;
      if (beat.in_last) begin
        // too short wins over a bad header, which wins over a length mismatch
        if (cnt < MIN_HDR_BYTES) want.parse_status = ST_SHORT;
        else if (ver_ihl[7:4] != IP_VERSION || ver_ihl[3:0] < MIN_IHL)
          want.parse_status = ST_BAD_HDR;
        else if (cnt != {1'b0, tot_len}) want.parse_status = ST_LEN_ERROR;
        else want.parse_status = ST_OK;
        want.source_addr = src_addr;
        want.dest_addr   = dst_addr;
        clear_packet();
      end
      want_beats.insert(want_beats.size(), want);
    endfunction

    function void field_mismatch(string name, logic [31:0] want, logic [31:0] got);
      errors++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    endfunction

    // Accepted result beat: compare against the oldest expected beat
    function void check_beat(ihp_out_t got);
      ihp_out_t want;
      if (want_beats.size() == 0) begin
        errors++;
        $error("result beat with nothing expected: 0x%0h", got);
        return;
      end
      want = want_beats.pop_front();
      if (got.payload_valid !== want.payload_valid)
        field_mismatch("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
      if (got.payload_byte !== want.payload_byte)
        field_mismatch("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
      if (got.packet_end !== want.packet_end)
        field_mismatch("packet_end", 32'(want.packet_end), 32'(got.packet_end));
      if (got.parse_status !== want.parse_status)
        field_mismatch("parse_status", 32'(want.parse_status), 32'(got.parse_status));
      if (got.source_addr !== want.source_addr)
        field_mismatch("source_addr", want.source_addr, got.source_addr);
      if (got.dest_addr !== want.dest_addr)
        field_mismatch("dest_addr", want.dest_addr, got.dest_addr);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  ihp_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  ihp_out_t    out_data;

  ipv4_parse_checker parse_chk;
  logic [7:0]        pkt_bytes[$];
  int unsigned       bytes_sent = 0;
  int unsigned       cycle_cnt = 0;
  bit                tx_calm = 1'b0;
  bit                all_calm = 1'b0;
  bit                hold_req = 1'b0;

  ipv4_header_parser_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) parse_chk.check_beat(out_data);
  end

  // Receiver: one long hold on request, otherwise random stall bursts and quiet stretches
  initial begin : rx_side
    int unsigned n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!all_calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 31) == 0) begin
        n = $urandom_range(20, 60);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Fill pkt_bytes with random content and the given header fields
  task automatic build_packet(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [15:0] tlen, input int unsigned n);
    pkt_bytes.delete();
    for (int unsigned i = 0; i < n; i++) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
    if (n > 0) pkt_bytes[0] = {ver, ihl};
    if (n > 2) pkt_bytes[2] = tlen[15:8];
    if (n > 3) pkt_bytes[3] = tlen[7:0];
  endtask

  // Send pkt_bytes, one beat per byte, last flag on the final one
  task automatic send_packet();
    int unsigned n;
    ihp_in_t     beat;
    for (int unsigned i = 0; i < pkt_bytes.size(); i++) begin
      if (!tx_calm && !all_calm && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
      beat.in_byte = pkt_bytes[i];
      beat.in_last = (i == pkt_bytes.size() - 1);
      in_valid <= 1'b1;
      in_data  <= beat;
      do @(posedge clk); while (in_stall);
      parse_chk.note_byte(beat);
      bytes_sent++;
    end
  endtask

  initial begin : stimulus
    int unsigned rand_base;
    int unsigned kind;
    int unsigned ihl;
    int unsigned tlen;
    parse_chk = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets
    build_packet(4'd4, 4'd5, 16'd20, 1);       // single byte: too short
    send_packet();
    build_packet(4'd4, 4'd5, 16'd19, 19);      // ends inside the destination address
    send_packet();
    build_packet(4'd4, 4'd5, 16'd20, 20);      // bare header, no payload
    send_packet();
    build_packet(4'd4, 4'd5, 16'd28, 28);      // payload at both byte extremes
    for (int unsigned i = 20; i < 28; i++) pkt_bytes[i] = i[0] ? 8'hFF : 8'h00;
    send_packet();
    build_packet(4'd6, 4'd5, 16'd26, 26);      // wrong version
    send_packet();
    build_packet(4'd4, 4'd4, 16'd26, 26);      // IHL below minimum
    send_packet();
    build_packet(4'd4, 4'd15, 16'd70, 70);     // maximum options
    send_packet();
    build_packet(4'd4, 4'd15, 16'd40, 40);     // header longer than total length
    send_packet();
    build_packet(4'd4, 4'd5, 16'd30, 35);      // runs past total length
    send_packet();
    build_packet(4'd4, 4'd5, 16'd50, 30);      // ends before total length
    send_packet();
    build_packet(4'd4, 4'd5, 16'd0, 24);       // zero total length
    send_packet();
    build_packet(4'd15, 4'd15, 16'hFFFF, 24);  // all ones
    for (int unsigned i = 0; i < 24; i++) pkt_bytes[i] = 8'hFF;
    send_packet();
    build_packet(4'd4, 4'd5, 16'd0, 22);       // all zeros
    for (int unsigned i = 0; i < 22; i++) pkt_bytes[i] = 8'h00;
    send_packet();

    // Random packets, mostly well formed; the receiver holds off at the start
    rand_base = bytes_sent;
    hold_req = 1'b1;
    while (bytes_sent - rand_base < RAND_BYTES) begin
      if (bytes_sent - rand_base > RAND_BYTES - CALM_TAIL) all_calm = 1'b1;
      tx_calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      tlen = ihl * 4 + $urandom_range(0, 40);
      case (kind)
        7: build_packet(IP_VERSION, 4'(ihl), 16'(tlen), $urandom_range(20, tlen + 10));
        8: build_packet(IP_VERSION, 4'(ihl), 16'(tlen), $urandom_range(1, 19));
        9: build_packet(4'($urandom), 4'($urandom), 16'($urandom), $urandom_range(1, 64));
        default: build_packet(IP_VERSION, 4'(ihl), 16'(tlen), tlen);
      endcase
      send_packet();
    end
    in_valid <= 1'b0;

    // Drain
    while (parse_chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (parse_chk.errors == 0 && parse_chk.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/ihp_pkg.sv
src/ihp_front.sv
src/ihp_queue.sv
src/ihp_back.sv
src/ipv4_header_parser_unit.sv
tb/sv/tb_top.sv
